// ===== hdl/slle_pkg.sv =====
`default_nettype none
package slle_pkg;

  localparam int DEPTH     = 1024;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int DATA_W    = 32;
  localparam int POS_W     = 10;
  localparam int CNT_W     = 10;
  localparam int MAX_ELEMS = DEPTH - 2;

  localparam logic [ADDR_W-1:0] FREE_SLOT = '0;
  localparam logic [ADDR_W-1:0] HEAD_SLOT = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] LAST_FREE = ADDR_W'(DEPTH - 2);

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_INS_NF,
    S_WALK,
    S_INS_LINK,
    S_DEL_NX,
    S_DEL_FREE,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/slle_ram.sv =====
`default_nettype none
module slle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hdl/static_linked_list_engine_unit.sv =====
`default_nettype none
// Array-backed singly linked list with its own free chain. Each input item
// inserts in_value before the 1-based in_position (in_req_type 0) or deletes
// the element at in_position (in_req_type 1); each yields one result item
// with out_status (0 ok, 1 error) and the element count after the request.
// The link store has one read port with registered data, and every walk step
// is one read of it. An insert runs S_INS_NF, S_WALK, S_INS_LINK, S_DONE; a
// delete S_WALK, S_DEL_NX, S_DEL_FREE, S_DONE. A request failing the
// position or free-slot check is answered from S_IDLE. After reset, an
// initialization pass over every slot writes the free chain into the link
// store; in_stall stays high until it finishes. At most 1022 elements fit.
module static_linked_list_engine_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_req_type,
  input  wire logic [slle_pkg::POS_W-1:0]    in_position,
  input  wire logic [slle_pkg::DATA_W-1:0]   in_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_status,
  output logic      [slle_pkg::CNT_W-1:0]    out_list_length
);

  slle_pkg::state_t state_r, state_nxt;

  logic [slle_pkg::ADDR_W-1:0] init_r, init_nxt;
  logic [slle_pkg::ADDR_W-1:0] k_r, k_nxt;
  logic [slle_pkg::POS_W-1:0]  step_r, step_nxt;
  logic [slle_pkg::ADDR_W-1:0] slot_r, slot_nxt;
  logic [slle_pkg::ADDR_W-1:0] victim_r, victim_nxt;
  logic                        req_r, req_nxt;
  logic [slle_pkg::DATA_W-1:0] value_r, value_nxt;
  logic [slle_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [slle_pkg::ADDR_W-1:0] free_head_r, free_head_nxt;
  logic                        status_r, status_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_status_r, out_status_nxt;
  logic [slle_pkg::CNT_W-1:0]  out_len_r, out_len_nxt;

  logic                        link_we;
  logic [slle_pkg::ADDR_W-1:0] link_waddr;
  logic [slle_pkg::ADDR_W-1:0] link_wdata;
  logic [slle_pkg::ADDR_W-1:0] link_raddr;
  logic [slle_pkg::ADDR_W-1:0] link_rdata;
  logic                        data_we;

  logic in_acc;
  logic out_free;
  logic ins_ok;
  logic del_ok;
  logic victim_ok;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != slle_pkg::S_IDLE) || !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_status      = out_status_r;
  assign out_list_length = out_len_r;

  assign ins_ok = (in_position != '0)
               && ({1'b0, in_position} <= ({1'b0, count_r} + (slle_pkg::CNT_W + 1)'(1)))
               && (free_head_r != slle_pkg::FREE_SLOT);
  assign del_ok = (in_position != '0) && (in_position <= count_r);
  assign victim_ok = (link_rdata != slle_pkg::FREE_SLOT)
                  && (link_rdata != slle_pkg::HEAD_SLOT);

  slle_ram #(
    .WIDTH (slle_pkg::ADDR_W),
    .DEPTH (slle_pkg::DEPTH)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata),
    .rd_addr (link_raddr),
    .rd_data (link_rdata)
  );

  slle_ram #(
    .WIDTH (slle_pkg::DATA_W),
    .DEPTH (slle_pkg::DEPTH)
  ) u_data_ram (
    .clk     (clk),
    .wr_en   (data_we),
    .wr_addr (slot_r),
    .wr_data (value_r),
    .rd_addr (slot_r),
    .rd_data ()
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      slle_pkg::S_INIT: begin
        if (init_r == slle_pkg::HEAD_SLOT) state_nxt = slle_pkg::S_IDLE;
      end
      slle_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_req_type == slle_pkg::REQ_INSERT) begin
            state_nxt = ins_ok ? slle_pkg::S_INS_NF : slle_pkg::S_IDLE;
          end else begin
            state_nxt = del_ok ? slle_pkg::S_WALK : slle_pkg::S_IDLE;
          end
        end
      end
      slle_pkg::S_INS_NF: state_nxt = slle_pkg::S_WALK;
      slle_pkg::S_WALK: begin
        if (step_r == '0) begin
          if (req_r == slle_pkg::REQ_INSERT) begin
            state_nxt = slle_pkg::S_INS_LINK;
          end else begin
            state_nxt = victim_ok ? slle_pkg::S_DEL_NX : slle_pkg::S_DONE;
          end
        end
      end
      slle_pkg::S_INS_LINK: state_nxt = slle_pkg::S_DONE;
      slle_pkg::S_DEL_NX:   state_nxt = slle_pkg::S_DEL_FREE;
      slle_pkg::S_DEL_FREE: state_nxt = slle_pkg::S_DONE;
      slle_pkg::S_DONE: begin
        if (out_free) state_nxt = slle_pkg::S_IDLE;
      end
      default: state_nxt = slle_pkg::S_INIT;
    endcase
  end

  always_comb begin
    init_nxt       = init_r;
    k_nxt          = k_r;
    step_nxt       = step_r;
    slot_nxt       = slot_r;
    victim_nxt     = victim_r;
    req_nxt        = req_r;
    value_nxt      = value_r;
    count_nxt      = count_r;
    free_head_nxt  = free_head_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_len_nxt    = out_len_r;
    link_we        = 1'b0;
    link_waddr     = k_r;
    link_wdata     = slot_r;
    link_raddr     = slle_pkg::HEAD_SLOT;
    data_we        = 1'b0;
    unique case (state_r)
      slle_pkg::S_INIT: begin
        link_we    = 1'b1;
        link_waddr = init_r;
        link_wdata = (init_r < slle_pkg::LAST_FREE)
                   ? init_r + slle_pkg::ADDR_W'(1) : slle_pkg::FREE_SLOT;
        init_nxt   = init_r + slle_pkg::ADDR_W'(1);
      end
      slle_pkg::S_IDLE: begin
        if (in_acc) begin
          req_nxt   = in_req_type;
          value_nxt = in_value;
          slot_nxt  = free_head_r;
          k_nxt     = slle_pkg::HEAD_SLOT;
          step_nxt  = in_position - slle_pkg::POS_W'(1);
          status_nxt = slle_pkg::STATUS_OK;
          if (in_req_type == slle_pkg::REQ_INSERT) begin
            link_raddr = free_head_r;
          end
          if ((in_req_type == slle_pkg::REQ_INSERT) ? !ins_ok : !del_ok) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = slle_pkg::STATUS_ERR;
            out_len_nxt    = count_r;
          end
        end
      end
      slle_pkg::S_INS_NF: begin
        free_head_nxt = link_rdata;
        data_we       = 1'b1;
        link_raddr    = slle_pkg::HEAD_SLOT;
      end
      slle_pkg::S_WALK: begin
        if (step_r != '0) begin
          k_nxt      = link_rdata;
          link_raddr = link_rdata;
          step_nxt   = step_r - slle_pkg::POS_W'(1);
        end else if (req_r == slle_pkg::REQ_INSERT) begin
          link_we    = 1'b1;
          link_waddr = slot_r;
          link_wdata = link_rdata;
        end else begin
          victim_nxt = link_rdata;
          link_raddr = link_rdata;
          if (!victim_ok) status_nxt = slle_pkg::STATUS_ERR;
        end
      end
      slle_pkg::S_INS_LINK: begin
        link_we    = 1'b1;
        link_waddr = k_r;
        link_wdata = slot_r;
        count_nxt  = count_r + slle_pkg::CNT_W'(1);
      end
      slle_pkg::S_DEL_NX: begin
        link_we    = 1'b1;
        link_waddr = k_r;
        link_wdata = link_rdata;
      end
      slle_pkg::S_DEL_FREE: begin
        link_we       = 1'b1;
        link_waddr    = victim_r;
        link_wdata    = free_head_r;
        free_head_nxt = victim_r;
        count_nxt     = count_r - slle_pkg::CNT_W'(1);
      end
      slle_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_len_nxt    = count_r;
        end
      end
      default: begin
        init_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slle_pkg::S_INIT;
      init_r      <= '0;
      count_r     <= '0;
      free_head_r <= slle_pkg::ADDR_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      count_r     <= count_nxt;
      free_head_r <= free_head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    step_r       <= step_nxt;
    slot_r       <= slot_nxt;
    victim_r     <= victim_nxt;
    req_r        <= req_nxt;
    value_r      <= value_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_len_r    <= out_len_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= slle_pkg::CNT_W'(slle_pkg::MAX_ELEMS))
    else $error("element count beyond capacity");

  a_free_head_not_head: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r != slle_pkg::HEAD_SLOT)
    else $error("data head slot on free chain");

  a_full_insert_err: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_req_type == slle_pkg::REQ_INSERT)
     && (free_head_r == slle_pkg::FREE_SLOT))
    |=> (out_valid_r && (out_status_r == slle_pkg::STATUS_ERR)))
    else $error("insert with empty free chain not rejected");

  a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != count_nxt)
    |-> ((state_r == slle_pkg::S_INS_LINK) || (state_r == slle_pkg::S_DEL_FREE)))
    else $error("element count changed outside link update");

endmodule
`default_nettype wire
